[hw/rtl/pipw_pkg.sv]
// ----------------------------------------------------------------------------
// Winding point-in-polygon package
// Coordinate widths, the vertex job that runs from the front end to the back
// end, and the per-edge result carried out of each cross-product lane.
// ----------------------------------------------------------------------------
package pipw_pkg;

   localparam int LAT_BITS       = 28;
   localparam int LON_BITS       = 29;
   localparam int WINDING_BITS   = 14;
   localparam int LAT_DIFF_BITS  = LAT_BITS + 1;
   localparam int LON_DIFF_BITS  = LON_BITS + 1;
   localparam int PROD_BITS      = LAT_DIFF_BITS + LON_DIFF_BITS;
   localparam int CROSS_BITS     = PROD_BITS + 1;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [LAT_BITS-1:0]      lat_type;
   typedef logic signed [LON_BITS-1:0]      lon_type;
   typedef logic signed [LAT_DIFF_BITS-1:0] lat_diff_type;
   typedef logic signed [LON_DIFF_BITS-1:0] lon_diff_type;
   typedef logic signed [PROD_BITS-1:0]     prod_type;
   typedef logic signed [CROSS_BITS-1:0]    cross_type;
   typedef logic [WINDING_BITS-1:0]         winding_type;
   typedef logic [QUEUE_PTR_BITS-1:0]       queue_ptr_type;
   typedef logic [QUEUE_CNT_BITS-1:0]       queue_cnt_type;

   typedef struct packed {
      lat_type point_lat;
      lon_type point_lon;
      lat_type prev_lat;
      lon_type prev_lon;
      lat_type vert_lat;
      lon_type vert_lon;
      lat_type start_lat;
      lon_type start_lon;
      logic    first;
      logic    last;
   } job_type;

   typedef struct packed {
      logic hit;
      logic inc;
      logic dec;
   } edge_res_type;

   function automatic winding_type winding_step(edge_res_type r);
      winding_type step;
      step = '0;
      if (r.inc) begin
         step = winding_type'(1);
      end else if (r.dec) begin
         step = '1;
      end
      return step;
   endfunction

endpackage

[hw/rtl/pipw_front.sv]
// ----------------------------------------------------------------------------
// Winding point-in-polygon front end
// Accepts vertex beats, keeps the query point, the start vertex and the
// previous vertex, and builds one job per beat for the queue.
// ----------------------------------------------------------------------------
module pipw_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pipw_pkg::lat_type req_vertex_lat,
   input  pipw_pkg::lon_type req_vertex_lon,
   input  pipw_pkg::lat_type req_query_lat,
   input  pipw_pkg::lon_type req_query_lon,
   input  logic              req_first_vertex,
   input  logic              req_last_vertex,
   input  logic              q_full,
   output logic              q_push,
   output pipw_pkg::job_type q_job
);
   import pipw_pkg::*;

   lat_type point_lat_ff, point_lat_in;
   lon_type point_lon_ff, point_lon_in;
   lat_type start_lat_ff, start_lat_in;
   lon_type start_lon_ff, start_lon_in;
   lat_type prev_lat_ff;
   lon_type prev_lon_ff;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      point_lat_in = req_first_vertex ? req_query_lat  : point_lat_ff;
      point_lon_in = req_first_vertex ? req_query_lon  : point_lon_ff;
      start_lat_in = req_first_vertex ? req_vertex_lat : start_lat_ff;
      start_lon_in = req_first_vertex ? req_vertex_lon : start_lon_ff;
   end

   always_comb begin
      q_job.point_lat = point_lat_in;
      q_job.point_lon = point_lon_in;
      q_job.prev_lat  = prev_lat_ff;
      q_job.prev_lon  = prev_lon_ff;
      q_job.vert_lat  = req_vertex_lat;
      q_job.vert_lon  = req_vertex_lon;
      q_job.start_lat = start_lat_in;
      q_job.start_lon = start_lon_in;
      q_job.first     = req_first_vertex;
      q_job.last      = req_last_vertex;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_lat_ff <= '0;
         point_lon_ff <= '0;
         start_lat_ff <= '0;
         start_lon_ff <= '0;
         prev_lat_ff  <= '0;
         prev_lon_ff  <= '0;
      end else if (q_push) begin
         point_lat_ff <= point_lat_in;
         point_lon_ff <= point_lon_in;
         start_lat_ff <= start_lat_in;
         start_lon_ff <= start_lon_in;
         prev_lat_ff  <= req_vertex_lat;
         prev_lon_ff  <= req_vertex_lon;
      end
   end

endmodule

[hw/rtl/pipw_queue.sv]
// ----------------------------------------------------------------------------
// Winding point-in-polygon job queue
// A short first-in first-out queue that decouples the front end from the
// back end.
// ----------------------------------------------------------------------------
module pipw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pipw_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output pipw_pkg::job_type head_job
);
   import pipw_pkg::*;

   job_type       entry_ff [QUEUE_DEPTH];
   queue_ptr_type wr_ptr_ff, rd_ptr_ff;
   queue_cnt_type count_ff, count_in;
   logic          do_pop;

   assign full       = (count_ff == queue_cnt_type'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + queue_cnt_type'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - queue_cnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + queue_ptr_type'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + queue_ptr_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[hw/rtl/pipw_edge.sv]
// ----------------------------------------------------------------------------
// Winding point-in-polygon edge lane
// Two-stage pipeline that forms the exact cross product of one edge against
// the query point and classifies the edge as a boundary hit, a downward
// crossing or an upward crossing.
// ----------------------------------------------------------------------------
module pipw_edge (
   input  logic                   clock,
   input  logic                   advance,
   input  pipw_pkg::lat_type      a_lat,
   input  pipw_pkg::lon_type      a_lon,
   input  pipw_pkg::lat_type      b_lat,
   input  pipw_pkg::lon_type      b_lon,
   input  pipw_pkg::lat_type      p_lat,
   input  pipw_pkg::lon_type      p_lon,
   output pipw_pkg::edge_res_type res
);
   import pipw_pkg::*;

   lat_diff_type dlat_ab_ff, dlat_pa_ff;
   lon_diff_type dlon_ab_ff, dlon_pa_ff;
   logic         in_box_ff, in_box_in;
   logic         a_above_ff, b_above_ff;
   prod_type     prod_bp_ff, prod_pb_ff;
   logic         in_box2_ff, a_above2_ff, b_above2_ff;
   cross_type    cross_val;
   logic         zero, neg, pos;

   always_comb begin
      in_box_in = ((p_lat >= a_lat && p_lat <= b_lat) || (p_lat >= b_lat && p_lat <= a_lat))
               && ((p_lon >= a_lon && p_lon <= b_lon) || (p_lon >= b_lon && p_lon <= a_lon));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dlat_ab_ff  <= lat_diff_type'(b_lat) - lat_diff_type'(a_lat);
         dlat_pa_ff  <= lat_diff_type'(p_lat) - lat_diff_type'(a_lat);
         dlon_ab_ff  <= lon_diff_type'(b_lon) - lon_diff_type'(a_lon);
         dlon_pa_ff  <= lon_diff_type'(p_lon) - lon_diff_type'(a_lon);
         in_box_ff   <= in_box_in;
         a_above_ff  <= (a_lon > p_lon);
         b_above_ff  <= (b_lon > p_lon);
         prod_bp_ff  <= prod_type'(dlat_ab_ff) * prod_type'(dlon_pa_ff);
         prod_pb_ff  <= prod_type'(dlat_pa_ff) * prod_type'(dlon_ab_ff);
         in_box2_ff  <= in_box_ff;
         a_above2_ff <= a_above_ff;
         b_above2_ff <= b_above_ff;
      end
   end

   always_comb begin
      cross_val = cross_type'(prod_bp_ff) - cross_type'(prod_pb_ff);
      zero      = (cross_val == '0);
      neg       = cross_val[CROSS_BITS-1];
      pos       = !neg && !zero;
      res.hit   = zero && in_box2_ff;
      res.inc   = !res.hit && a_above2_ff && !b_above2_ff && neg;
      res.dec   = !res.hit && !a_above2_ff && b_above2_ff && pos;
   end

endmodule

[hw/rtl/pipw_back.sv]
// ----------------------------------------------------------------------------
// Winding point-in-polygon back end
// Runs the edge to the current vertex and the closing edge in two lanes,
// keeps the winding count and boundary flag, and holds the result beat.
// ----------------------------------------------------------------------------
module pipw_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  pipw_pkg::job_type q_job,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_inside_res,
   output logic              rsp_on_boundary
);
   import pipw_pkg::*;

   logic         advance;
   logic         s1_valid_ff, s1_first_ff, s1_last_ff;
   logic         s2_valid_ff, s2_first_ff, s2_last_ff;
   edge_res_type res_prev, res_close;
   edge_res_type use_prev, use_close;
   winding_type  winding_ff, winding_in;
   logic         hit_ff, hit_in;
   logic         rsp_valid_ff, inside_ff, boundary_ff;

   assign advance         = !rsp_valid_ff || !rsp_stall;
   assign q_pop           = advance;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_inside_res  = inside_ff;
   assign rsp_on_boundary = boundary_ff;

   pipw_edge u_edge_prev (
      .clock   (clock),
      .advance (advance),
      .a_lat   (q_job.prev_lat),
      .a_lon   (q_job.prev_lon),
      .b_lat   (q_job.vert_lat),
      .b_lon   (q_job.vert_lon),
      .p_lat   (q_job.point_lat),
      .p_lon   (q_job.point_lon),
      .res     (res_prev)
   );

   pipw_edge u_edge_close (
      .clock   (clock),
      .advance (advance),
      .a_lat   (q_job.vert_lat),
      .a_lon   (q_job.vert_lon),
      .b_lat   (q_job.start_lat),
      .b_lon   (q_job.start_lon),
      .p_lat   (q_job.point_lat),
      .p_lon   (q_job.point_lon),
      .res     (res_close)
   );

   always_comb begin
      use_prev   = s2_first_ff ? '0 : res_prev;
      use_close  = s2_last_ff ? res_close : '0;
      winding_in = (s2_first_ff ? '0 : winding_ff)
                 + winding_step(use_prev) + winding_step(use_close);
      hit_in     = (hit_ff && !s2_first_ff) || use_prev.hit || use_close.hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s1_first_ff  <= 1'b0;
         s1_last_ff   <= 1'b0;
         s2_first_ff  <= 1'b0;
         s2_last_ff   <= 1'b0;
         winding_ff   <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= q_valid;
         s1_first_ff  <= q_job.first;
         s1_last_ff   <= q_job.last;
         s2_valid_ff  <= s1_valid_ff;
         s2_first_ff  <= s1_first_ff;
         s2_last_ff   <= s1_last_ff;
         rsp_valid_ff <= s2_valid_ff && s2_last_ff;
         if (s2_valid_ff) begin
            winding_ff <= winding_in;
            hit_ff     <= hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         inside_ff   <= (winding_in != '0) || hit_in;
         boundary_ff <= hit_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_result_follows_last: assert property (@(posedge clock) disable iff (reset)
      advance && s2_valid_ff && s2_last_ff |=> rsp_valid_ff)
      else $error("result beat missing after a closing vertex");

   a_prev_lane_exclusive: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> !(res_prev.inc && res_prev.dec)
                   && !(res_prev.hit && (res_prev.inc || res_prev.dec)))
      else $error("edge lane reports conflicting classes");

   a_close_lane_exclusive: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> !(res_close.inc && res_close.dec)
                   && !(res_close.hit && (res_close.inc || res_close.dec)))
      else $error("closing lane reports conflicting classes");

   a_stalled_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> !s2_valid_ff || $stable(s2_last_ff))
      else $error("back pipeline moved while the result beat was stalled");
`endif

endmodule

[hw/rtl/point_in_polygon_winding_core.sv]
// ----------------------------------------------------------------------------
// Winding point-in-polygon core
// Streams polygon vertices and reports whether a query point lies inside the
// polygon or on its boundary.
// ----------------------------------------------------------------------------
// Unless req_stall is high, the core takes one vertex beat per clock cycle,
// including the last vertex of a polygon: the edge from the previous vertex
// and the closing edge back to the first vertex run in two parallel
// cross-product lanes, each a two-stage pipeline with one multiplier per
// product. The first vertex of a polygon also carries the query point. A
// four-entry queue separates beat acceptance from the lanes; while a result
// beat is stalled the lanes hold and the queue fills.
module point_in_polygon_winding_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pipw_pkg::lat_type req_vertex_lat,
   input  pipw_pkg::lon_type req_vertex_lon,
   input  pipw_pkg::lat_type req_query_lat,
   input  pipw_pkg::lon_type req_query_lon,
   input  logic              req_first_vertex,
   input  logic              req_last_vertex,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_inside_res,
   output logic              rsp_on_boundary
);
   import pipw_pkg::*;

   logic    q_full, q_push, q_pop, q_valid;
   job_type push_job, head_job;

   pipw_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_vertex_lat   (req_vertex_lat),
      .req_vertex_lon   (req_vertex_lon),
      .req_query_lat    (req_query_lat),
      .req_query_lon    (req_query_lon),
      .req_first_vertex (req_first_vertex),
      .req_last_vertex  (req_last_vertex),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_job            (push_job)
   );

   pipw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (head_job)
   );

   pipw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_job           (head_job),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_inside_res  (rsp_inside_res),
      .rsp_on_boundary (rsp_on_boundary)
   );

endmodule

[tb/pipw_checker.sv]
// ----------------------------------------------------------------------------
// Winding point-in-polygon verdict checker
// Watches the vertex and result channels of the core, keeps its own copy of
// the polygon state, works out the verdict for every closing vertex and
// compares each result beat with the oldest verdict still outstanding.
// ----------------------------------------------------------------------------
module pipw_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  pipw_pkg::lat_type req_vertex_lat,
   input  pipw_pkg::lon_type req_vertex_lon,
   input  pipw_pkg::lat_type req_query_lat,
   input  pipw_pkg::lon_type req_query_lon,
   input  logic              req_first_vertex,
   input  logic              req_last_vertex,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              rsp_inside_res,
   input  logic              rsp_on_boundary,
   output int                fail_count,
   output int                verdicts_pending
);
   import pipw_pkg::*;

   typedef struct packed {
      logic inside_res;
      logic on_boundary;
   } polygon_verdict_type;

   polygon_verdict_type expected_verdicts[$];

   longint      pt_lat;
   longint      pt_lon;
   longint      org_lat;
   longint      org_lon;
   longint      last_lat;
   longint      last_lon;
   winding_type winding;
   logic        boundary_seen;
   int          verdict_count;

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      fail_count++;
   endtask

   function automatic void trace_edge(longint a_lat, longint a_lon,
                                      longint b_lat, longint b_lon);
      longint cp;
      cp = (b_lat - a_lat) * (pt_lon - a_lon) - (pt_lat - a_lat) * (b_lon - a_lon);
      if (cp == 0
          && ((pt_lat >= a_lat && pt_lat <= b_lat) || (pt_lat >= b_lat && pt_lat <= a_lat))
          && ((pt_lon >= a_lon && pt_lon <= b_lon) || (pt_lon >= b_lon && pt_lon <= a_lon)))
      begin
         boundary_seen = 1'b1;
      end else if (a_lon > pt_lon && b_lon <= pt_lon) begin
         if (cp < 0) begin
            winding = winding + winding_type'(1);
         end
      end else if (a_lon <= pt_lon && b_lon > pt_lon) begin
         if (cp > 0) begin
            winding = winding - winding_type'(1);
         end
      end
   endfunction

   function automatic void absorb_vertex(lat_type v_lat, lon_type v_lon,
                                         lat_type q_lat, lon_type q_lon,
                                         logic first, logic last);
      polygon_verdict_type verdict;
      if (first) begin
         pt_lat        = q_lat;
         pt_lon        = q_lon;
         org_lat       = v_lat;
         org_lon       = v_lon;
         winding       = '0;
         boundary_seen = 1'b0;
      end else begin
         trace_edge(last_lat, last_lon, v_lat, v_lon);
      end
      last_lat = v_lat;
      last_lon = v_lon;
      if (last) begin
         trace_edge(v_lat, v_lon, org_lat, org_lon);
         verdict.inside_res  = (winding != '0) || boundary_seen;
         verdict.on_boundary = boundary_seen;
         expected_verdicts.push_back(verdict);
      end
   endfunction

   always @(posedge clock) begin : check_beats
      polygon_verdict_type want;
      if (reset) begin
         pt_lat        = 0;
         pt_lon        = 0;
         org_lat       = 0;
         org_lon       = 0;
         last_lat      = 0;
         last_lon      = 0;
         winding       = '0;
         boundary_seen = 1'b0;
         verdict_count = 0;
         expected_verdicts.delete();
         verdicts_pending <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_vertex(req_vertex_lat, req_vertex_lon, req_query_lat, req_query_lon,
                          req_first_vertex, req_last_vertex);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("result beat with no verdict outstanding");
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_inside_res !== want.inside_res) begin
                  report_mismatch($sformatf("verdict %0d inside_res %b, expected %b",
                                            verdict_count, rsp_inside_res,
                                            want.inside_res));
               end
               if (rsp_on_boundary !== want.on_boundary) begin
                  report_mismatch($sformatf("verdict %0d on_boundary %b, expected %b",
                                            verdict_count, rsp_on_boundary,
                                            want.on_boundary));
               end
               verdict_count++;
            end
         end
         verdicts_pending <= expected_verdicts.size();
      end
   end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// Winding point-in-polygon testbench
// Streams directed and random polygons into the core with random gaps and
// result stalls, including polygons walked in both directions round the
// query point; a checker beside the core predicts and compares every result
// beat.
// ----------------------------------------------------------------------------
module tb_top;
   import pipw_pkg::*;

   localparam int STALL_LIMIT  = 1000;
   localparam int RANDOM_ITEMS = 1200;

   localparam int MODE_GRID    = 0;
   localparam int MODE_GEO     = 1;
   localparam int MODE_RAW     = 2;
   localparam int MODE_EXTREME = 3;

   localparam lat_type LAT_MAX = {1'b0, {(LAT_BITS-1){1'b1}}};
   localparam lat_type LAT_MIN = {1'b1, {(LAT_BITS-1){1'b0}}};
   localparam lon_type LON_MAX = {1'b0, {(LON_BITS-1){1'b1}}};
   localparam lon_type LON_MIN = {1'b1, {(LON_BITS-1){1'b0}}};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   lat_type req_vertex_lat = '0;
   lon_type req_vertex_lon = '0;
   lat_type req_query_lat = '0;
   lon_type req_query_lon = '0;
   logic    req_first_vertex = 1'b0;
   logic    req_last_vertex = 1'b0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   logic    rsp_inside_res;
   logic    rsp_on_boundary;
   logic    steady = 1'b0;
   int      fail_count;
   int      verdicts_pending;
   int      idle_cycles = 0;

   always #1 clock = ~clock;

   point_in_polygon_winding_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_vertex_lat   (req_vertex_lat),
      .req_vertex_lon   (req_vertex_lon),
      .req_query_lat    (req_query_lat),
      .req_query_lon    (req_query_lon),
      .req_first_vertex (req_first_vertex),
      .req_last_vertex  (req_last_vertex),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_on_boundary  (rsp_on_boundary)
   );

   pipw_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_vertex_lat   (req_vertex_lat),
      .req_vertex_lon   (req_vertex_lon),
      .req_query_lat    (req_query_lat),
      .req_query_lon    (req_query_lon),
      .req_first_vertex (req_first_vertex),
      .req_last_vertex  (req_last_vertex),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_on_boundary  (rsp_on_boundary),
      .fail_count       (fail_count),
      .verdicts_pending (verdicts_pending)
   );

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 30);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic lat_type pick_lat(int mode);
      int sel;
      sel = $urandom_range(0, 3);
      case (mode)
         MODE_GRID: return lat_type'(int'($urandom_range(0, 8)) - 4);
         MODE_GEO: return lat_type'(int'($urandom_range(0, 180000000)) - 90000000);
         MODE_EXTREME: return (sel == 0) ? LAT_MIN : (sel == 1) ? LAT_MAX : lat_type'(sel - 2);
         default: return lat_type'($urandom);
      endcase
   endfunction

   function automatic lon_type pick_lon(int mode);
      int sel;
      sel = $urandom_range(0, 3);
      case (mode)
         MODE_GRID: return lon_type'(int'($urandom_range(0, 8)) - 4);
         MODE_GEO: return lon_type'(int'($urandom_range(0, 360000000)) - 180000000);
         MODE_EXTREME: return (sel == 0) ? LON_MIN : (sel == 1) ? LON_MAX : lon_type'(sel - 2);
         default: return lon_type'($urandom);
      endcase
   endfunction

   task automatic send_vertex(lat_type v_lat, lon_type v_lon, lat_type q_lat, lon_type q_lon,
                              logic first, logic last);
      while (!steady && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_vertex_lat   <= v_lat;
      req_vertex_lon   <= v_lon;
      req_query_lat    <= q_lat;
      req_query_lon    <= q_lon;
      req_first_vertex <= first;
      req_last_vertex  <= last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_polygon(int verts, int mode);
      lat_type q_lat;
      lon_type q_lon;
      q_lat = pick_lat(mode);
      q_lon = pick_lon(mode);
      for (int k = 0; k < verts; k++) begin
         if (k == 0) begin
            send_vertex(pick_lat(mode), pick_lon(mode), q_lat, q_lon, 1'b1, verts == 1);
         end else begin
            send_vertex(pick_lat(mode), pick_lon(mode), pick_lat(MODE_RAW),
                        pick_lon(MODE_RAW), 1'b0, k == verts - 1);
         end
      end
   endtask

   initial begin
      @(negedge reset);
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int items;
      int span;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Before any first vertex, then carrying on from the kept state.
      send_vertex(3, 3, 7, 7, 1'b0, 1'b1);
      send_vertex(-3, 5, 1, 1, 1'b0, 1'b1);
      // One-vertex polygons, on and off the vertex.
      send_vertex(2, -2, 2, -2, 1'b1, 1'b1);
      send_vertex(2, -2, 0, 0, 1'b1, 1'b1);
      // A square walked in both directions round the point, then one with the
      // point on an edge.
      send_vertex(-5, -5, 0, 0, 1'b1, 1'b0);
      send_vertex(5, -5, 0, 0, 1'b0, 1'b0);
      send_vertex(5, 5, 0, 0, 1'b0, 1'b0);
      send_vertex(-5, 5, 0, 0, 1'b0, 1'b1);
      send_vertex(-5, 5, 0, 0, 1'b1, 1'b0);
      send_vertex(5, 5, 0, 0, 1'b0, 1'b0);
      send_vertex(5, -5, 0, 0, 1'b0, 1'b0);
      send_vertex(-5, -5, 0, 0, 1'b0, 1'b1);
      send_vertex(-5, -5, 5, 0, 1'b1, 1'b0);
      send_vertex(5, -5, 0, 0, 1'b0, 1'b0);
      send_vertex(5, 5, 0, 0, 1'b0, 1'b0);
      send_vertex(-5, 5, 0, 0, 1'b0, 1'b1);
      // Triangles spanning the full coordinate range.
      send_vertex(LAT_MIN, LON_MIN, 0, 0, 1'b1, 1'b0);
      send_vertex(LAT_MAX, LON_MIN, 0, 0, 1'b0, 1'b0);
      send_vertex(0, LON_MAX, 0, 0, 1'b0, 1'b1);
      send_vertex(LAT_MAX, LON_MAX, LAT_MIN, LON_MAX, 1'b1, 1'b0);
      send_vertex(LAT_MIN, LON_MIN, 0, 0, 1'b0, 1'b0);
      send_vertex(LAT_MIN, LON_MAX, 0, 0, 1'b0, 1'b1);

      items = 0;
      while (items < RANDOM_ITEMS) begin
         steady <= (items >= 400 && items < 700);
         if ($urandom_range(0, 99) < 80) begin
            span = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            send_polygon(span, $urandom_range(MODE_GRID, MODE_EXTREME));
            items += span;
         end else begin
            send_vertex(pick_lat(MODE_GRID), pick_lon(MODE_GRID), pick_lat(MODE_RAW),
                        pick_lon(MODE_RAW), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
            items++;
         end
      end
      steady <= 1'b0;

      req_valid <= 1'b0;
      do @(negedge clock); while (verdicts_pending != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[point_in_polygon_winding_core.f]
hw/rtl/pipw_pkg.sv
hw/rtl/pipw_front.sv
hw/rtl/pipw_queue.sv
hw/rtl/pipw_edge.sv
hw/rtl/pipw_back.sv
hw/rtl/point_in_polygon_winding_core.sv
tb/pipw_checker.sv
tb/tb_top.sv
